>>> design/first_fit_segment_allocator_unit_assert.svh
// Assertion macros for the first-fit segment allocator.
// Used by the top level only; needs i_clk and i_rst_n in scope.
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define FFSA_ASSERT_IMP(label, lhs, rhs) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (lhs) |-> (rhs)) \
        else $error("ffsa assertion failed");

// Implication whose consequent is checked in the next cycle, outside reset.
`define FFSA_ASSERT_NEXT(label, lhs, rhs) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (lhs) |=> (rhs)) \
        else $error("ffsa assertion failed");

`endif

>>> design/ffsa_pkg.sv
// Package for the first-fit segment allocator: sizes, codes, FSM states
// and controller/datapath interface structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ffsa_pkg;
    localparam int MAX_CHUNKS_DEF   = 64;
    localparam int HEADER_BYTES_DEF = 16;
    localparam int ADDR_BITS_DEF    = 24;
    localparam int FIELD_BITS       = 24;
    localparam logic [FIELD_BITS-1:0] ARENA_RESET = 24'd8388608;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FIT  = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_SPLIT_WR,
        S_MERGE_RD,
        S_MERGE_CHK,
        S_DEL_RD,
        S_DEL_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic init;        // reinitialize table
        logic capture;     // latch input transaction
        logic scan_rd;     // read entry at scan index
        logic scan_next;   // advance scan index
        logic grant;       // mark scan entry reserved, maybe shrink
        logic shift_rd;    // read entry below insertion point
        logic shift_wr;    // move it up one place
        logic split_wr;    // write new free chunk
        logic merge_rd;    // read entry after freed one
        logic merge_acc;   // absorb next entry into freed one
        logic merge_end;   // write back freed entry
        logic del_rd;      // read entry for removal shift
        logic del_wr;      // move it down one place
        logic finish;      // drive result
        logic [1:0] stat;
    } t_cmd;

    typedef struct packed {
        logic op;
        logic scan_end;    // scan index reached count
        logic hit;         // current entry matches
        logic split_ok;
        logic shift_end;
        logic merge_ok;    // next entry exists and is free
        logic merge_last;  // absorbed entry is the last one, nothing to move
        logic del_end;
    } t_sts;
endpackage
`default_nettype wire

>>> design/first_fit_segment_allocator_unit.sv
// First-fit segment allocator, top level.
// Issue a transaction with start while busy is low: i_op selects allocate
// (i_request_bytes) or free (i_address). One result per transaction is shown
// for one cycle with o_done, carrying o_status and o_payload_address; the
// receiver cannot stall it. The chunk table lives in one RAM of MAX_CHUNKS
// entries with registered read, so every table step is a read state followed by
// a check or write state. An allocate scans the chunks in order (a miss checks
// one slot past the end); when it splits, it moves the later entries up one
// place and writes the new free chunk. The result state comes last; o_done
// follows in the cycle after it. A free merges the run of free chunks after the
// freed one, moving the later entries down for each merged chunk. One
// transaction at a time; the next may start in the o_done cycle.
// Configuration: i_cfg_valid/o_cfg_ready write arena_bytes; this rebuilds the
// table as one free chunk. o_cfg_ready is high while idle and start is low.
// After reset the table is rebuilt (busy is high then) with the default arena
// size.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_segment_allocator_unit #(
    parameter int MAX_CHUNKS   = ffsa_pkg::MAX_CHUNKS_DEF,
    parameter int HEADER_BYTES = ffsa_pkg::HEADER_BYTES_DEF,
    parameter int ADDR_BITS    = ffsa_pkg::ADDR_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            i_op,
    input  wire logic [ffsa_pkg::FIELD_BITS-1:0] i_request_bytes,
    input  wire logic [ffsa_pkg::FIELD_BITS-1:0] i_address,
    output logic                                 o_done,
    output logic [1:0]                           o_status,
    output logic [ffsa_pkg::FIELD_BITS-1:0]      o_payload_address,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [ffsa_pkg::FIELD_BITS-1:0] i_cfg_data
);
    import ffsa_pkg::*;

    t_cmd   cmd;
    t_sts   sts;
    t_state state;
    logic   cfg_wr;
    logic [FIELD_BITS-1:0] arena;

    assign o_cfg_ready = !busy && !start;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign arena       = cfg_wr ? i_cfg_data : ARENA_RESET;

    ffsa_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_cfg  (cfg_wr),
        .i_sts  (sts),
        .o_cmd  (cmd),
        .o_busy (busy),
        .o_state(state)
    );

    ffsa_datapath #(
        .MAX_CHUNKS  (MAX_CHUNKS),
        .HEADER_BYTES(HEADER_BYTES),
        .ADDR_BITS   (ADDR_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .i_arena  (arena),
        .i_op     (i_op),
        .i_req    (i_request_bytes),
        .i_addr   (i_address),
        .o_payload(o_payload_address),
        .o_status (o_status),
        .o_done   (o_done)
    );

`include "first_fit_segment_allocator_unit_assert.svh"

    // a result follows only the result state
    `FFSA_ASSERT_NEXT(a_done_after_finish, state == S_DONE, o_done)
    // an accepted transaction makes the block busy
    `FFSA_ASSERT_NEXT(a_busy_after_start, start && !busy && !cfg_wr, busy)
    // an unknown-address result carries a zero payload address
    `FFSA_ASSERT_IMP(a_alloc_status, o_done && o_status == ST_UNKNOWN, o_payload_address == '0)
endmodule
`default_nettype wire

>>> design/ffsa_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ffsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> design/ffsa_datapath.sv
// Datapath: chunk table RAM, scan/shift indexes, arithmetic for split and merge.
// Depends on ffsa_pkg and ffsa_ram.
`timescale 1ns / 1ps
`default_nettype none
module ffsa_datapath #(
    parameter int MAX_CHUNKS   = ffsa_pkg::MAX_CHUNKS_DEF,
    parameter int HEADER_BYTES = ffsa_pkg::HEADER_BYTES_DEF,
    parameter int ADDR_BITS    = ffsa_pkg::ADDR_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire ffsa_pkg::t_cmd                    i_cmd,
    output ffsa_pkg::t_sts                         o_sts,
    input  wire logic [ffsa_pkg::FIELD_BITS-1:0]   i_arena,
    input  wire logic                              i_op,
    input  wire logic [ffsa_pkg::FIELD_BITS-1:0]   i_req,
    input  wire logic [ffsa_pkg::FIELD_BITS-1:0]   i_addr,
    output logic [ffsa_pkg::FIELD_BITS-1:0]        o_payload,
    output logic [1:0]                             o_status,
    output logic                                   o_done
);
    import ffsa_pkg::*;

    localparam int IW = $clog2(MAX_CHUNKS);
    localparam int CW = $clog2(MAX_CHUNKS + 1);
    localparam int EW = ADDR_BITS + FIELD_BITS + 1;
    localparam logic [CW-1:0] MAXC = CW'(MAX_CHUNKS);
    localparam logic [FIELD_BITS:0] HDR = (FIELD_BITS+1)'(HEADER_BYTES);

    logic             r_op;
    logic [FIELD_BITS-1:0] r_req;
    logic [ADDR_BITS-1:0]  r_addr;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx;      // scan or merge base index
    logic [CW-1:0]    r_mv;       // shift pointer
    logic [ADDR_BITS-1:0]  r_off;   // offset of hit entry
    logic [FIELD_BITS-1:0] r_size;  // size of hit entry (accumulated on merge)
    logic [FIELD_BITS-1:0] r_rem;
    logic [FIELD_BITS-1:0] r_pay;
    logic             r_done;

    logic             we;
    logic [IW-1:0]    waddr, raddr;
    logic [EW-1:0]    wdata, rdata;
    logic [ADDR_BITS-1:0]  rd_off;
    logic [FIELD_BITS-1:0] rd_size;
    logic             rd_res;
    logic [ADDR_BITS-1:0]  rd_pay;
    logic [FIELD_BITS:0]   msum;

    assign {rd_off, rd_size, rd_res} = rdata;
    assign rd_pay = rd_off + ADDR_BITS'(HEADER_BYTES);
    assign msum   = {1'b0, r_size} + {1'b0, rd_size} + HDR;

    ffsa_ram #(.WIDTH(EW), .DEPTH(MAX_CHUNKS)) u_tbl (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // select read address
    always_comb begin
        raddr = r_idx[IW-1:0];
        if (i_cmd.shift_rd) begin
            raddr = IW'(r_mv - CW'(1));
        end else if (i_cmd.merge_rd) begin
            raddr = IW'(r_idx + CW'(1));
        end else if (i_cmd.del_rd) begin
            raddr = IW'(r_mv + CW'(1));
        end
    end

    // select write port
    always_comb begin
        we    = 1'b0;
        waddr = r_idx[IW-1:0];
        wdata = {r_off, r_size, 1'b0};
        if (i_cmd.init) begin
            we    = 1'b1;
            waddr = '0;
            wdata = {{ADDR_BITS{1'b0}}, i_arena, 1'b0};
        end else if (i_cmd.grant) begin
            we    = 1'b1;
            wdata = {rd_off, (o_sts.split_ok ? r_req : rd_size), 1'b1};
        end else if (i_cmd.shift_wr) begin
            we    = 1'b1;
            waddr = r_mv[IW-1:0];
            wdata = rdata;
        end else if (i_cmd.split_wr) begin
            we    = 1'b1;
            waddr = IW'(r_idx + CW'(1));
            wdata = {r_off + ADDR_BITS'(HEADER_BYTES) + ADDR_BITS'(r_req),
                     r_rem - FIELD_BITS'(HEADER_BYTES), 1'b0};
        end else if (i_cmd.merge_end) begin
            we    = 1'b1;
        end else if (i_cmd.del_wr) begin
            we    = 1'b1;
            waddr = r_mv[IW-1:0];
            wdata = rdata;
        end
    end

    // status toward the controller
    always_comb begin
        o_sts.op         = r_op;
        o_sts.scan_end   = (r_idx >= r_count);
        o_sts.hit        = (r_op == OP_ALLOC) ? (!rd_res && rd_size >= r_req)
                                              : (rd_pay == r_addr);
        o_sts.split_ok   = (rd_size - r_req >= FIELD_BITS'(HEADER_BYTES)) &&
                           (r_count < MAXC);
        o_sts.shift_end  = (r_mv <= r_idx + CW'(1));
        o_sts.merge_ok   = (r_idx + CW'(1) < r_count) && !rd_res;
        o_sts.merge_last = (r_idx + CW'(2) >= r_count);
        o_sts.del_end    = (r_mv + CW'(2) >= r_count);
    end

    // count update
    always_comb begin
        n_count = r_count;
        if (i_cmd.init) begin
            n_count = CW'(1);
        end else if (i_cmd.split_wr) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.del_wr && o_sts.del_end) begin
            n_count = r_count - CW'(1);
        end else if (i_cmd.merge_acc && (r_count == r_idx + CW'(2))) begin
            n_count = r_count - CW'(1);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= i_cmd.finish;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_op;
            r_req  <= i_req;
            r_addr <= ADDR_BITS'(i_addr);
            r_idx  <= '0;
            r_pay  <= '0;
        end
        if (i_cmd.scan_next) begin
            r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.scan_rd && o_sts.hit && !o_sts.scan_end) begin
            r_off  <= rd_off;
            r_size <= rd_size;
            r_rem  <= rd_size - r_req;
        end
        if (i_cmd.grant) begin
            r_pay <= FIELD_BITS'(rd_pay);
            r_mv  <= r_count;
        end
        if (i_cmd.shift_wr) begin
            r_mv <= r_mv - CW'(1);
        end
        if (i_cmd.merge_acc) begin
            r_size <= msum[FIELD_BITS-1:0];
            r_mv   <= r_idx + CW'(1);
        end
        if (i_cmd.del_wr) begin
            r_mv <= r_mv + CW'(1);
        end
        if (i_cmd.finish) begin
            o_status  <= i_cmd.stat;
            o_payload <= (i_cmd.stat == ST_OK && r_op == OP_ALLOC) ? r_pay : '0;
        end
    end

    assign o_done = r_done;
endmodule
`default_nettype wire

>>> design/ffsa_ctrl.sv
// Controller FSM for the first-fit segment allocator.
// Depends on ffsa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ffsa_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic           i_cfg,
    input  wire ffsa_pkg::t_sts i_sts,
    output ffsa_pkg::t_cmd      o_cmd,
    output logic                o_busy,
    output ffsa_pkg::t_state    o_state
);
    import ffsa_pkg::*;

    t_state r_state, n_state;
    logic   r_init;   // table rewrite pending after reset
    logic   r_fit;    // alloc found a chunk
    logic   n_fit;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_init  <= 1'b1;
            r_fit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_init  <= 1'b0;
            r_fit   <= n_fit;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_fit   = r_fit;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && !r_init && !i_cfg) n_state = S_SCAN_RD;
            end
            S_SCAN_RD:  n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                priority if (i_sts.scan_end) begin
                    n_state = S_DONE;
                end else if (i_sts.hit) begin
                    if (i_sts.op == OP_ALLOC) begin
                        n_state = i_sts.split_ok ? S_SHIFT_RD : S_DONE;
                    end else begin
                        n_state = S_MERGE_RD;
                    end
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: n_state = S_SHIFT_WR;
            S_SHIFT_WR: n_state = i_sts.shift_end ? S_SPLIT_WR : S_SHIFT_RD;
            S_SPLIT_WR: n_state = S_DONE;
            S_MERGE_RD: n_state = S_MERGE_CHK;
            S_MERGE_CHK: begin
                if (i_sts.merge_ok && !i_sts.merge_last) n_state = S_DEL_RD;
                else if (i_sts.merge_ok) n_state = S_MERGE_RD;
                else n_state = S_DONE;
            end
            S_DEL_RD:   n_state = S_DEL_WR;
            S_DEL_WR:   n_state = i_sts.del_end ? S_MERGE_RD : S_DEL_RD;
            S_DONE:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
        if (r_state == S_IDLE) n_fit = 1'b0;
        if (r_state == S_SCAN_CHK && !i_sts.scan_end && i_sts.hit &&
            i_sts.op == OP_ALLOC) begin
            n_fit = 1'b1;
        end
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.init    = r_init || i_cfg;
                o_cmd.capture = i_start && !r_init && !i_cfg;
            end
            S_SCAN_RD:  o_cmd.scan_rd = 1'b0;
            S_SCAN_CHK: begin
                o_cmd.scan_rd = 1'b1;
                if (!i_sts.scan_end && i_sts.hit && i_sts.op == OP_ALLOC) begin
                    o_cmd.grant = 1'b1;
                end else if (!i_sts.scan_end && !i_sts.hit) begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            S_SHIFT_RD: o_cmd.shift_rd = 1'b1;
            S_SHIFT_WR: o_cmd.shift_wr = 1'b1;
            S_SPLIT_WR: o_cmd.split_wr = 1'b1;
            S_MERGE_RD: o_cmd.merge_rd = 1'b1;
            S_MERGE_CHK: begin
                o_cmd.merge_rd  = 1'b1;
                o_cmd.merge_acc = i_sts.merge_ok;
                o_cmd.merge_end = !i_sts.merge_ok;
            end
            S_DEL_RD:   o_cmd.del_rd = 1'b1;
            S_DEL_WR:   o_cmd.del_wr = 1'b1;
            S_DONE: begin
                o_cmd.finish = 1'b1;
                if (r_fit) o_cmd.stat = ST_OK;
                else if (i_sts.op == OP_ALLOC) o_cmd.stat = ST_NO_FIT;
                else o_cmd.stat = i_sts.scan_end ? ST_UNKNOWN : ST_OK;
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_busy  = (r_state != S_IDLE) || r_init;
    assign o_state = r_state;
endmodule
`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for first_fit_segment_allocator_unit.
// Needs ffsa_pkg and the top level; a scoreboard class predicts each result.
`timescale 1ns / 1ps

class alloc_scoreboard;
    localparam int CHUNKS = ffsa_pkg::MAX_CHUNKS_DEF;
    localparam int HDR    = ffsa_pkg::HEADER_BYTES_DEF;

    logic [23:0] chunk_off [CHUNKS];
    logic [23:0] chunk_len [CHUNKS];
    bit          chunk_rsv [CHUNKS];
    int          chunk_cnt;
    logic [1:0]  want_status [$];
    logic [23:0] want_addr [$];
    int          errors;
    int          checked;

    // Rebuild the table as one free chunk
    function void set_arena(logic [23:0] bytes);
        for (int k = 0; k < CHUNKS; k++) begin
            chunk_off[k] = '0;
            chunk_len[k] = '0;
            chunk_rsv[k] = 0;
        end
        chunk_len[0] = bytes;
        chunk_cnt = 1;
    endfunction

    function void shift_up(int idx);
        for (int k = chunk_cnt; k > idx; k--) begin
            chunk_off[k] = chunk_off[k-1];
            chunk_len[k] = chunk_len[k-1];
            chunk_rsv[k] = chunk_rsv[k-1];
        end
        chunk_cnt++;
    endfunction

    function void shift_down(int idx);
        for (int k = idx; k + 1 < chunk_cnt; k++) begin
            chunk_off[k] = chunk_off[k+1];
            chunk_len[k] = chunk_len[k+1];
            chunk_rsv[k] = chunk_rsv[k+1];
        end
        chunk_cnt--;
    endfunction

    // Predict one transaction, queue the expected result and hand it back
    function void note_input(logic op, logic [23:0] req, logic [23:0] addr,
                             output logic [1:0] st, output logic [23:0] pay);
        logic [23:0] rem;
        logic [23:0] hit_pay;
        bit done;
        done = 0;
        st = ffsa_pkg::ST_NO_FIT;
        pay = '0;
        if (op == ffsa_pkg::OP_ALLOC) begin
            for (int i = 0; i < chunk_cnt && !done; i++) begin
                if (!chunk_rsv[i] && chunk_len[i] >= req) begin
                    rem = chunk_len[i] - req;
                    chunk_rsv[i] = 1;
                    if (rem >= HDR && chunk_cnt < CHUNKS) begin
                        chunk_len[i] = req;
                        shift_up(i + 1);
                        chunk_off[i+1] = chunk_off[i] + 24'(HDR) + req;
                        chunk_len[i+1] = rem - 24'(HDR);
                        chunk_rsv[i+1] = 0;
                    end
                    st = ffsa_pkg::ST_OK;
                    pay = chunk_off[i] + 24'(HDR);
                    done = 1;
                end
            end
        end else begin
            st = ffsa_pkg::ST_UNKNOWN;
            for (int i = 0; i < chunk_cnt && !done; i++) begin
                hit_pay = chunk_off[i] + 24'(HDR);
                if (hit_pay == addr) begin
                    chunk_rsv[i] = 0;
                    // absorb the run of free chunks that follows
                    while (i + 1 < chunk_cnt && !chunk_rsv[i+1]) begin
                        chunk_len[i] = chunk_len[i] + chunk_len[i+1] + 24'(HDR);
                        shift_down(i + 1);
                    end
                    st = ffsa_pkg::ST_OK;
                    done = 1;
                end
            end
        end
        want_status.push_back(st);
        want_addr.push_back(pay);
    endfunction

    // Payload offset of some chunk in the table, free or reserved
    function logic [23:0] any_payload();
        return chunk_off[$urandom_range(chunk_cnt - 1)] + 24'(HDR);
    endfunction

    task report(string what);
        $display("mismatch at %0t: %s", $time, what);
        errors++;
    endtask

    task check(logic [1:0] st, logic [23:0] pay);
        logic [1:0] es;
        logic [23:0] ea;
        if (want_status.size() == 0) begin
            report($sformatf("unexpected result status %0d addr %0d", st, pay));
        end else begin
            es = want_status.pop_front();
            ea = want_addr.pop_front();
            checked++;
            if (st !== es)
                report($sformatf("status %0d, predicted %0d", st, es));
            if (pay !== ea)
                report($sformatf("payload_address %0d, predicted %0d", pay, ea));
        end
    endtask
endclass

module testbench;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic        i_op = 0;
    logic [23:0] i_request_bytes = '0;
    logic [23:0] i_address = '0;
    logic        o_done;
    logic [1:0]  o_status;
    logic [23:0] o_payload_address;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [23:0] i_cfg_data = '0;

    alloc_scoreboard sb = new();
    logic [23:0] live_addr [$];
    int          idle_pct;
    int          sent;
    int          cfg_writes;

    first_fit_segment_allocator_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_op(i_op), .i_request_bytes(i_request_bytes), .i_address(i_address),
        .o_done(o_done), .o_status(o_status), .o_payload_address(o_payload_address),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Check every result strobe
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check(o_status, o_payload_address);
    end

    // Issue one transaction, optionally after an idle gap
    task send(logic op, logic [23:0] req, logic [23:0] addr);
        logic [1:0] st;
        logic [23:0] pay;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        start <= 1;
        i_op <= op;
        i_request_bytes <= req;
        i_address <= addr;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_input(op, req, addr, st, pay);
        sent++;
        // track granted payloads so most frees hit a real chunk
        if (st == ffsa_pkg::ST_OK && op == ffsa_pkg::OP_ALLOC)
            live_addr.push_back(pay);
        @(negedge i_clk);
    endtask

    // Hold off until every predicted result has come back
    task drain();
        start <= 0;
        while (sb.want_status.size() != 0) @(negedge i_clk);
    endtask

    task write_arena(logic [23:0] bytes);
        drain();
        i_cfg_valid <= 1;
        i_cfg_data <= bytes;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_arena(bytes);
        live_addr.delete();
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task random_item(logic [23:0] arena);
        int pick;
        int idx;
        logic [23:0] req;
        logic [23:0] addr;
        pick = $urandom_range(99);
        req = 24'($urandom);
        addr = 24'($urandom);
        if (pick < 55) begin
            case ($urandom_range(9))
                0: req = 24'($urandom);
                1: req = 24'($urandom_range(arena));
                default: req = 24'($urandom_range(64));
            endcase
            send(ffsa_pkg::OP_ALLOC, req, addr);
        end else if (pick < 92 && live_addr.size() > 0) begin
            idx = $urandom_range(live_addr.size() - 1);
            addr = live_addr[idx];
            live_addr.delete(idx);
            send(ffsa_pkg::OP_FREE, req, addr);
        end else if (pick < 96) begin
            send(ffsa_pkg::OP_FREE, req, sb.any_payload());
        end else begin
            send(ffsa_pkg::OP_FREE, req, addr);
        end
    endtask

    initial begin
        logic [23:0] arenas [6];
        arenas = '{24'd4096, 24'd1000, 24'd16777215, 24'd2048, 24'd1, 24'd0};
        sb.set_arena(ffsa_pkg::ARENA_RESET);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        idle_pct = 29;

        // Directed: reset arena, zero request, no fit, free of a free chunk, unknown free
        send(ffsa_pkg::OP_ALLOC, 24'd0, 24'hFFFFFF);
        send(ffsa_pkg::OP_ALLOC, 24'hFFFFFF, 24'd0);
        send(ffsa_pkg::OP_ALLOC, 24'd100, 24'd0);
        send(ffsa_pkg::OP_FREE, 24'hFFFFFF, 24'd32);
        send(ffsa_pkg::OP_FREE, 24'd0, 24'd32);
        send(ffsa_pkg::OP_FREE, 24'd0, 24'hFFFFFF);
        send(ffsa_pkg::OP_FREE, 24'd0, 24'd0);
        send(ffsa_pkg::OP_FREE, 24'd0, 24'd16);
        // Zero arena
        write_arena(24'd0);
        send(ffsa_pkg::OP_ALLOC, 24'd0, 24'd0);
        send(ffsa_pkg::OP_ALLOC, 24'd0, 24'd0);
        send(ffsa_pkg::OP_FREE, 24'd0, 24'd16);
        // Largest arena: the payload of the split chunk wraps past the top of the address space
        write_arena(24'hFFFFFF);
        send(ffsa_pkg::OP_ALLOC, 24'd16777190, 24'd0);
        send(ffsa_pkg::OP_ALLOC, 24'd9, 24'd0);
        send(ffsa_pkg::OP_FREE, 24'd0, 24'd6);
        send(ffsa_pkg::OP_FREE, 24'd0, 24'd16);
        send(ffsa_pkg::OP_ALLOC, 24'hFFFFFF, 24'd0);
        // Smallest nonzero arena
        write_arena(24'd1);
        send(ffsa_pkg::OP_ALLOC, 24'd1, 24'd0);
        send(ffsa_pkg::OP_ALLOC, 24'd2, 24'd0);
        send(ffsa_pkg::OP_FREE, 24'd0, 24'd16);

        // Random phases: sender idles 29, then 47, then never
        for (int p = 0; p < 6; p++) begin
            idle_pct = (p < 2) ? 29 : (p < 4) ? 47 : 0;
            write_arena(arenas[p]);
            for (int n = 0; n < 255; n++) begin
                if (n == 120) drain();
                random_item(arenas[p]);
            end
        end

        drain();
        repeat (300) @(posedge i_clk);
        $display("Covered %0d transactions over %0d arena writes, %0d results checked.",
                 sent, cfg_writes, sb.checked);
        $display("Arena sizes from 0 to 16777215, full tables, wrapped offsets, bad frees.");
        if (sb.errors == 0 && sb.want_status.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(4 * 20000000);
        $display("Regression FAIL");
        $finish;
    end
endmodule
